// ===== sv/owtcs_pkg.sv =====
// Shared types, codes and helper functions for the tag code sequencer.
package owtcs_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] code_value;
    logic [2:0]  tag_type;
    logic        check_enable;
    logic        old_command;
    logic        bus_presence;
    logic [7:0]  bus_read_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  bus_op;
    logic [7:0]  op_byte;
    logic [9:0]  wait_amount;
    logic [3:0]  status;
    logic [63:0] read_code;
    logic [1:0]  found_type;
    logic        last;
  } out_item_t;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_DETECT = 2'd2;
  localparam logic [1:0] REQ_RESP   = 2'd3;

  localparam logic [3:0] OP_RESET = 4'd0;
  localparam logic [3:0] OP_WBYTE = 4'd1;
  localparam logic [3:0] OP_RBYTE = 4'd2;
  localparam logic [3:0] OP_SBIT  = 4'd3;
  localparam logic [3:0] OP_SBYTE = 4'd4;
  localparam logic [3:0] OP_BIT   = 4'd5;
  localparam logic [3:0] OP_WUS   = 4'd6;
  localparam logic [3:0] OP_WMS   = 4'd7;
  localparam logic [3:0] OP_DEPWR = 4'd8;
  localparam logic [3:0] OP_FIN   = 4'd9;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NODEV     = 4'd1;
  localparam logic [3:0] ST_CRC       = 4'd2;
  localparam logic [3:0] ST_ZERO      = 4'd3;
  localparam logic [3:0] ST_BADTYPE   = 4'd4;
  localparam logic [3:0] ST_UNDET     = 4'd5;
  localparam logic [3:0] ST_TYPEMIS   = 4'd6;
  localparam logic [3:0] ST_VERIFYMIS = 4'd7;
  localparam logic [3:0] ST_PROGMIS   = 4'd8;

  localparam logic [1:0] CFG_BIT_WAIT  = 2'd0;
  localparam logic [1:0] CFG_PROG_WAIT = 2'd1;
  localparam logic [1:0] CFG_PULSE     = 2'd2;

  localparam logic [7:0] CMD_READ     = 8'h33;
  localparam logic [7:0] CMD_READ_OLD = 8'h0F;
  localparam logic [7:0] CMD_EN_INV   = 8'hD1;
  localparam logic [7:0] CMD_EN_NORM  = 8'h1D;
  localparam logic [7:0] CMD_EN_UNDET = 8'hC1;
  localparam logic [7:0] CMD_PROBE_A  = 8'hB5;
  localparam logic [7:0] CMD_PROBE_B  = 8'h1E;
  localparam logic [7:0] CMD_WRITE    = 8'hD5;
  localparam logic [7:0] CMD_PROBE_C  = 8'hAA;
  localparam logic [7:0] CMD_PROG     = 8'h3C;
  localparam logic [7:0] ANS_FE       = 8'hFE;

  localparam int unsigned MAX_OPS = 12;
  localparam int unsigned QDEPTH  = 4;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
    logic [9:0] amount;
  } bus_cmd_t;

  // One step of work for the back end: a list of operations and maybe a finish.
  typedef struct packed {
    bus_cmd_t [MAX_OPS-1:0] ops;
    logic [3:0]  n_ops;
    logic        fin;
    logic [3:0]  status;
    logic [63:0] code;
    logic [1:0]  found;
  } job_t;

  function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] cbyte(input logic [63:0] c, input logic [2:0] i);
    return c[{i, 3'b000} +: 8];
  endfunction

endpackage

// ===== sv/one_wire_tag_code_sequencer_core.sv =====
// Top level: configuration registers, front end, job queue and back end.
// An item's job is registered in the front, written to the queue, and presented from the back's output register.
// Throughput: one input beat per cycle into the front while its job register can drain;
// one result beat per cycle out of the back while out_ready is high.
// Reset (rst, synchronous): sequencer idle, queue empty, registers 10, 50, 600.
module one_wire_tag_code_sequencer_core import owtcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  logic [4:0] bit_wait_ms;
  logic [7:0] program_wait_ms;
  logic [9:0] pulse_setup_us;
  logic       fj_valid, fj_ready, bj_valid, bj_ready;
  job_t       fj, bj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_wait_ms <= 5'd10; program_wait_ms <= 8'd50; pulse_setup_us <= 10'd600;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIT_WAIT:  bit_wait_ms <= cfg_data[4:0];
        CFG_PROG_WAIT: program_wait_ms <= cfg_data[7:0];
        CFG_PULSE:     pulse_setup_us <= cfg_data;
        default: ;
      endcase
    end
  end

  owtcs_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .bit_wait_ms, .program_wait_ms, .pulse_setup_us,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  owtcs_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  owtcs_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bus_op == OP_FIN |-> out_data.last)
    else $error("finish beat not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bus_op != OP_FIN |-> out_data.status == ST_OK)
    else $error("status on a non-finish beat");

endmodule

// ===== sv/owtcs_front.sv =====
// Front end: takes requests and bus responses, runs the job state and builds jobs.
module owtcs_front import owtcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic [4:0] bit_wait_ms,
  input  logic [7:0] program_wait_ms,
  input  logic [9:0] pulse_setup_us,
  output logic       job_valid,
  input  logic       job_ready,
  output job_t       job
);

  typedef enum logic [19:0] {
    PH_IDLE    = 20'd1 << 0,  PH_RD_PRES = 20'd1 << 1,  PH_RD_BYTE = 20'd1 << 2,
    PH_A_PRES1 = 20'd1 << 3,  PH_A_PRES2 = 20'd1 << 4,  PH_A_BYTE  = 20'd1 << 5,
    PH_B_PRES1 = 20'd1 << 6,  PH_B_PRES2 = 20'd1 << 7,  PH_B_BYTE  = 20'd1 << 8,
    PH_B_PRES3 = 20'd1 << 9,  PH_C_PRES1 = 20'd1 << 10, PH_C_BYTE1 = 20'd1 << 11,
    PH_C_BYTE2 = 20'd1 << 12, PH_C_PRES2 = 20'd1 << 13, PH_W_PRES1 = 20'd1 << 14,
    PH_W_PRES2 = 20'd1 << 15, PH_W_PRES3 = 20'd1 << 16, PH_P_PRES  = 20'd1 << 17,
    PH_P_CRC   = 20'd1 << 18, PH_P_CONF  = 20'd1 << 19
  } phase_t;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_DETECT = 2'd2;

  phase_t      phase, phase_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] target_code, target_code_next;
  logic [63:0] captured_code, captured_code_next;
  logic [2:0]  active_type, active_type_next;
  logic [1:0]  kind, kind_next;
  logic        flag, flag_next;
  logic [7:0]  crc_acc, crc_acc_next;
  logic [7:0]  code_crc;
  logic [7:0]  probe_c_crc;
  logic        out_empty;
  job_t        jb, job_reg;
  logic        jvalid;

  assign in_ready  = !jvalid || job_ready;
  assign job_valid = jvalid;
  assign job       = job_reg;
  assign probe_c_crc = crc_add(crc_add(crc_add(8'h00, CMD_PROBE_C), 8'h00), 8'h00);

  // Code checksum over bytes 0..6 of a write request.
  always_comb begin
    code_crc = 8'h00;
    for (int i = 0; i < 7; i++) code_crc = crc_add(code_crc, in_data.code_value[8*i +: 8]);
  end

  always_comb begin
    logic        inv, pres, hit, check, fail;
    logic [7:0]  b, en;
    logic [2:0]  bi;
    logic [1:0]  tk;
    logic [1:0]  tres;  // 0 not found, 1 found, 2 no presence
    logic        do_test, do_start_write, do_start_read, do_done;
    phase_t      tph;
    phase_next = phase; byte_count_next = byte_count; target_code_next = target_code;
    captured_code_next = captured_code; active_type_next = active_type;
    kind_next = kind; flag_next = flag; crc_acc_next = crc_acc;
    jb = '0;
    pres = in_data.bus_presence;
    b = in_data.bus_read_byte;
    inv = (active_type == 3'd1);
    en = (active_type == 3'd1) ? CMD_EN_INV : (active_type == 3'd2) ? CMD_EN_NORM : CMD_EN_UNDET;
    bi = 3'd0; tk = 2'd1; tres = 2'd0; hit = 1'b0; check = 1'b0; fail = 1'b0;
    do_test = 1'b0; do_start_write = 1'b0; do_start_read = 1'b0; do_done = 1'b0;
    tph = PH_A_PRES1;
    out_empty = 1'b0;

    unique case (in_data.req_type)
      REQ_READ: begin
        kind_next = KIND_READ; flag_next = in_data.old_command; active_type_next = 3'd0;
        do_start_read = 1'b1;
      end
      REQ_DETECT: begin
        kind_next = KIND_DETECT; flag_next = 1'b0; active_type_next = 3'd0;
        tk = 2'd1; do_test = 1'b1;
      end
      REQ_WRITE: begin
        target_code_next = in_data.code_value;
        kind_next = KIND_WRITE; flag_next = in_data.check_enable; active_type_next = 3'd0;
        check = in_data.check_enable;
        if (check && code_crc != in_data.code_value[63:56]) begin
          jb.fin = 1'b1; jb.status = ST_CRC; phase_next = PH_IDLE;
        end else if (check && in_data.code_value == 64'd0) begin
          jb.fin = 1'b1; jb.status = ST_ZERO; phase_next = PH_IDLE;
        end else if (in_data.tag_type > 3'd4) begin
          jb.fin = 1'b1; jb.status = ST_BADTYPE; phase_next = PH_IDLE;
        end else if (in_data.tag_type == 3'd0) begin
          tk = 2'd1; do_test = 1'b1;
        end else begin
          active_type_next = in_data.tag_type;
          if (check && in_data.tag_type <= 3'd3) begin
            tk = in_data.tag_type[1:0]; do_test = 1'b1;
          end else begin
            jb.ops[0] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd1;
            phase_next = (in_data.tag_type == 3'd3) ? PH_P_PRES : PH_W_PRES1;
          end
        end
      end
      default: begin
        // Bus response: a test that ends sets tres/tk and is resolved below.
        unique case (phase)
          PH_RD_PRES: begin
            if (!pres) begin
              jb.fin = 1'b1; jb.status = (kind == KIND_READ) ? ST_NODEV : ST_VERIFYMIS;
              phase_next = PH_IDLE;
            end else begin
              jb.ops[0] = '{OP_WBYTE, (kind == KIND_READ && flag) ? CMD_READ_OLD : CMD_READ,
                            10'd0};
              jb.ops[1] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd2;
              phase_next = PH_RD_BYTE;
            end
          end
          PH_RD_BYTE: begin
            bi = byte_count[2:0];
            if (bi != 3'd7) crc_acc_next = crc_add(crc_acc, b);
            captured_code_next = captured_code | ({56'd0, b} << {bi, 3'b000});
            byte_count_next = {1'b0, bi} + 4'd1;
            if (bi != 3'd7) begin
              jb.ops[0] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd1;
            end else begin
              jb.fin = 1'b1; phase_next = PH_IDLE;
              if (kind == KIND_READ) begin
                jb.code = captured_code_next;
                jb.status = (crc_acc != b) ? ST_CRC :
                            (captured_code_next == 64'd0) ? ST_ZERO : ST_OK;
              end else begin
                jb.status = (captured_code_next == target_code) ? ST_OK : ST_VERIFYMIS;
              end
            end
          end
          PH_A_PRES1, PH_B_PRES1: begin
            tk = (phase == PH_A_PRES1) ? 2'd1 : 2'd2;
            if (!pres) begin hit = 1'b1; tres = 2'd2; end
            else begin
              jb.ops[0] = '{OP_WBYTE, (tk == 2'd1) ? CMD_EN_INV : CMD_EN_NORM, 10'd0};
              jb.ops[1] = '{OP_SBIT, 8'h01, {5'd0, bit_wait_ms}};
              jb.ops[2] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd3;
              phase_next = (tk == 2'd1) ? PH_A_PRES2 : PH_B_PRES2;
            end
          end
          PH_A_PRES2, PH_B_PRES2: begin
            tk = (phase == PH_A_PRES2) ? 2'd1 : 2'd2;
            if (!pres) begin hit = 1'b1; tres = 2'd2; end
            else begin
              jb.ops[0] = '{OP_WBYTE, (tk == 2'd1) ? CMD_PROBE_A : CMD_PROBE_B, 10'd0};
              jb.ops[1] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd2;
              phase_next = (tk == 2'd1) ? PH_A_BYTE : PH_B_BYTE;
            end
          end
          PH_A_BYTE: begin
            tk = 2'd1; hit = 1'b1; tres = (b == ANS_FE) ? 2'd1 : 2'd0;
          end
          PH_B_BYTE: begin
            tk = 2'd2;
            if (b == ANS_FE) begin
              jb.ops[0] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd1;
              phase_next = PH_B_PRES3;
            end else begin hit = 1'b1; tres = 2'd0; end
          end
          PH_B_PRES3: begin
            tk = 2'd2; hit = 1'b1;
            if (!pres) tres = 2'd2;
            else begin
              tres = 2'd1;
              jb.ops[0] = '{OP_WBYTE, CMD_EN_NORM, 10'd0};
              jb.ops[1] = '{OP_SBIT, 8'h00, {5'd0, bit_wait_ms}};
              jb.ops[2] = '{OP_DEPWR, 8'h00, 10'd0}; jb.n_ops = 4'd3;
            end
          end
          PH_C_PRES1: begin
            tk = 2'd3;
            if (!pres) begin hit = 1'b1; tres = 2'd2; end
            else begin
              jb.ops[0] = '{OP_WBYTE, CMD_PROBE_C, 10'd0};
              jb.ops[1] = '{OP_WBYTE, 8'h00, 10'd0};
              jb.ops[2] = '{OP_WBYTE, 8'h00, 10'd0};
              jb.ops[3] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd4;
              phase_next = PH_C_BYTE1;
            end
          end
          PH_C_BYTE1: begin
            tk = 2'd3;
            if (b == probe_c_crc) begin
              jb.ops[0] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd1;
              phase_next = PH_C_BYTE2;
            end else begin hit = 1'b1; tres = 2'd0; end
          end
          PH_C_BYTE2: begin
            jb.ops[0] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd1;
            phase_next = PH_C_PRES2;
          end
          PH_C_PRES2: begin
            tk = 2'd3; hit = 1'b1; tres = pres ? 2'd1 : 2'd2;
          end
          PH_W_PRES1, PH_W_PRES3: begin
            if (!pres) begin jb.fin = 1'b1; jb.status = ST_NODEV; phase_next = PH_IDLE; end
            else begin
              jb.ops[0] = '{OP_WBYTE, en, 10'd0};
              jb.ops[1] = '{OP_SBIT, {7'd0, (phase == PH_W_PRES1) ? !inv : inv},
                            {5'd0, bit_wait_ms}};
              if (phase == PH_W_PRES1) begin
                jb.ops[2] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd3;
                phase_next = PH_W_PRES2;
              end else begin
                jb.n_ops = 4'd2; do_done = 1'b1;
              end
            end
          end
          PH_W_PRES2: begin
            if (!pres) begin jb.fin = 1'b1; jb.status = ST_NODEV; phase_next = PH_IDLE; end
            else begin
              jb.ops[0] = '{OP_WBYTE, CMD_WRITE, 10'd0};
              for (int i = 0; i < 8; i++)
                jb.ops[i+1] = '{OP_SBYTE, target_code[8*i +: 8] ^ {8{inv}},
                                {5'd0, bit_wait_ms}};
              jb.ops[9] = '{OP_RESET, 8'h00, 10'd0}; jb.n_ops = 4'd10;
              phase_next = PH_W_PRES3;
            end
          end
          PH_P_PRES: begin
            if (!pres) begin jb.fin = 1'b1; jb.status = ST_NODEV; phase_next = PH_IDLE; end
            else begin
              jb.ops[0] = '{OP_WBYTE, CMD_PROG, 10'd0};
              jb.ops[1] = '{OP_WBYTE, 8'h00, 10'd0};
              jb.ops[2] = '{OP_WBYTE, 8'h00, 10'd0};
              jb.ops[3] = '{OP_WBYTE, target_code[7:0], 10'd0};
              jb.ops[4] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd5;
              byte_count_next = 4'd0;
              phase_next = PH_P_CRC;
            end
          end
          PH_P_CRC: begin
            jb.ops[0] = '{OP_WUS, 8'h00, pulse_setup_us};
            jb.ops[1] = '{OP_BIT, 8'h01, 10'd0};
            jb.ops[2] = '{OP_WMS, 8'h00, {2'd0, program_wait_ms}};
            jb.ops[3] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd4;
            phase_next = PH_P_CONF;
          end
          PH_P_CONF: begin
            bi = byte_count[2:0];
            if (b != cbyte(target_code, bi)) begin
              jb.fin = 1'b1; jb.status = ST_PROGMIS; phase_next = PH_IDLE;
              byte_count_next = {1'b0, bi};
            end else begin
              byte_count_next = {1'b0, bi} + 4'd1;
              if (bi != 3'd7) begin
                jb.ops[0] = '{OP_WBYTE, cbyte(target_code, bi + 3'd1), 10'd0};
                jb.ops[1] = '{OP_RBYTE, 8'h00, 10'd0}; jb.n_ops = 4'd2;
                phase_next = PH_P_CRC;
              end else do_done = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            out_empty = 1'b1;
          end
        endcase

        // Outcome of a type test.
        if (hit) begin
          if (tres == 2'd2) begin
            jb.fin = 1'b1; jb.status = ST_NODEV; phase_next = PH_IDLE;
          end else if (kind == KIND_DETECT) begin
            if (tres == 2'd1) begin
              jb.fin = 1'b1; jb.found = tk; phase_next = PH_IDLE;
            end else if (tk != 2'd3) begin
              tk = tk + 2'd1; do_test = 1'b1;
            end else begin
              jb.fin = 1'b1; phase_next = PH_IDLE;
            end
          end else if (tres == 2'd1) begin
            active_type_next = {1'b0, tk}; do_start_write = 1'b1;
          end else if (active_type == 3'd0) begin
            if (tk != 2'd3) begin tk = tk + 2'd1; do_test = 1'b1; end
            else begin jb.fin = 1'b1; jb.status = ST_UNDET; phase_next = PH_IDLE; end
          end else begin
            jb.fin = 1'b1; jb.status = ST_TYPEMIS; phase_next = PH_IDLE;
          end
        end
        if (do_done) begin
          if (flag) do_start_read = 1'b1;
          else begin jb.fin = 1'b1; jb.status = ST_OK; phase_next = PH_IDLE; end
        end
      end
    endcase

    // Starting steps append a bus reset after any operations already queued.
    tph = (tk == 2'd1) ? PH_A_PRES1 : (tk == 2'd2) ? PH_B_PRES1 : PH_C_PRES1;
    if (do_test || do_start_write || do_start_read) begin
      jb.ops[jb.n_ops] = '{OP_RESET, 8'h00, 10'd0};
      jb.n_ops = jb.n_ops + 4'd1;
    end
    if (do_test) phase_next = tph;
    if (do_start_write) phase_next = (tk == 2'd3) ? PH_P_PRES : PH_W_PRES1;
    if (do_start_read) begin
      byte_count_next = 4'd0; captured_code_next = 64'd0; crc_acc_next = 8'h00;
      phase_next = PH_RD_PRES;
    end
    if (in_data.req_type == REQ_RESP && phase == PH_IDLE) out_empty = 1'b1;
    fail = out_empty;
    if (fail) jb = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; byte_count <= '0; target_code <= '0; captured_code <= '0;
      active_type <= '0; kind <= KIND_READ; flag <= 1'b0; crc_acc <= '0; jvalid <= 1'b0;
    end else begin
      if (job_ready) jvalid <= 1'b0;
      if (in_valid && in_ready) begin
        phase <= phase_next; byte_count <= byte_count_next;
        target_code <= target_code_next; captured_code <= captured_code_next;
        active_type <= active_type_next; kind <= kind_next; flag <= flag_next;
        crc_acc <= crc_acc_next;
        jvalid <= !out_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) job_reg <= jb;
  end

endmodule

// ===== sv/owtcs_queue.sv =====
// Short job queue between the front and the back end.
module owtcs_queue import owtcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int unsigned AW = $clog2(QDEPTH);

  job_t          mem [QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          wr, rd;

  assign wr_ready = (count != QDEPTH[AW:0]);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

endmodule

// ===== sv/owtcs_back.sv =====
// Back end: plays out one job's operations and finish as output beats.
module owtcs_back import owtcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [3:0] idx;
  logic [3:0] total;
  logic       is_last;
  logic       is_fin;
  out_item_t  beat;
  logic       ovalid;
  out_item_t  oreg;
  logic       take;

  assign total   = job.n_ops + {3'd0, job.fin};
  assign is_last = (idx + 4'd1 == total);
  assign is_fin  = job.fin && (idx == job.n_ops);
  assign take    = job_valid && (!ovalid || out_ready);
  assign job_ready = take && is_last;
  assign out_valid = ovalid;
  assign out_data  = oreg;

  always_comb begin
    beat = '0;
    if (is_fin) begin
      beat.bus_op = OP_FIN; beat.status = job.status;
      beat.read_code = job.code; beat.found_type = job.found;
    end else begin
      beat.bus_op = job.ops[idx].op;
      beat.op_byte = job.ops[idx].data;
      beat.wait_amount = job.ops[idx].amount;
    end
    beat.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; ovalid <= 1'b0;
    end else begin
      if (out_ready) ovalid <= 1'b0;
      if (take) begin
        ovalid <= 1'b1;
        idx <= is_last ? 4'd0 : idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) oreg <= beat;
  end

endmodule
